/* rtl/load_cell_adc_reader_with_tare_top_assert.svh */
// Assertion macros used by the checker file of the load cell reader.
`ifndef LOAD_CELL_ADC_READER_WITH_TARE_TOP_ASSERT_SVH
`define LOAD_CELL_ADC_READER_WITH_TARE_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LCADC_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("lcadc assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define LCADC_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("lcadc assertion failed");

`endif

/* rtl/lcadc_pkg.sv */
`default_nettype none
package lcadc_pkg;

    localparam int RAW_W    = 24;
    localparam int WEIGHT_W = 28;
    localparam int HALF_W   = 8;
    localparam int GAP_W    = 16;

    localparam logic [WEIGHT_W-1:0] WEIGHT_MAX = '1;
    localparam logic [HALF_W-1:0]   HALF_RST   = 8'd5;
    localparam logic [GAP_W-1:0]    GAP_RST    = 16'd213;

    localparam logic [1:0] MODE_TICK  = 2'd0;
    localparam logic [1:0] MODE_WEIGH = 2'd1;
    localparam logic [1:0] MODE_TARE  = 2'd2;

    localparam logic REG_HALF = 1'b0;
    localparam logic REG_GAP  = 1'b1;

    typedef struct packed {
        logic [1:0] mode;
        logic       dout_pin;
    } lcadc_in_t;

    typedef struct packed {
        logic                sck_pin;
        logic                busy_res;
        logic                done_res;
        logic [RAW_W-1:0]    raw_value;
        logic [WEIGHT_W-1:0] weight;
        logic                weight_updated;
    } lcadc_out_t;

    typedef struct packed {
        logic busy;
        logic done;
    } lcadc_div_stat_t;

endpackage
`default_nettype wire

/* rtl/lcadc_div.sv */
`default_nettype none
module lcadc_div
    import lcadc_pkg::*;
#(
    parameter int NW = 29,
    parameter int DW = 16
) (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            start,
    input  wire logic [NW-1:0]   dividend,
    input  wire logic [DW-1:0]   divisor,
    output logic      [NW-1:0]   quotient,
    output lcadc_div_stat_t      stat
);

    localparam int CW = $clog2(NW + 1);

    logic          busy_reg;
    logic          done_reg;
    logic [CW-1:0] cnt_reg;
    logic [DW-1:0] rem_reg;
    logic [NW-1:0] quo_reg;
    logic [DW-1:0] dvs_reg;

    logic [DW:0]   rem_sh;
    logic [DW:0]   rem_sub;
    logic          bit_ge;

    // Restoring division, one quotient bit a cycle. The dividend shifts out
    // of the top of quo_reg while quotient bits shift in at the bottom.
    always_comb begin
        rem_sh  = {rem_reg, quo_reg[NW-1]};
        bit_ge  = (rem_sh >= {1'b0, dvs_reg});
        rem_sub = bit_ge ? (rem_sh - {1'b0, dvs_reg}) : rem_sh;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(NW);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end else if (busy_reg) begin
            rem_reg <= rem_sub[DW-1:0];
            quo_reg <= {quo_reg[NW-2:0], bit_ge};
        end
    end

    assign quotient  = quo_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule
`default_nettype wire

/* rtl/load_cell_adc_reader_with_tare_top.sv */
// An accepted beat gives its result beat in the next cycle, except the beat that ends a
// weigh read with raw above tare and a non-zero divisor, which waits for the divider.
// Throughput: one beat a cycle while the divider is neither busy nor done and the output is free
// or taken; the long case is set by the bit-serial divider, one quotient bit per cycle, no beat taken.
// Reset (aresetn, synchronous, active low): idle, clock high, readings and tare cleared,
// half period 5 ticks, divisor 213 half units.
`default_nettype none
module load_cell_adc_reader_with_tare_top
    import lcadc_pkg::*;
#(
    parameter int DATA_BITS = 24,
    parameter int FRAC_BITS = 4
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire lcadc_in_t        s_data,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output lcadc_out_t            m_data,
    input  wire logic             cfg_wr_en,
    input  wire logic             cfg_index,
    input  wire logic [GAP_W-1:0] cfg_wr_data
);

    localparam int NW  = DATA_BITS + FRAC_BITS + 1;
    localparam int QW  = (NW > WEIGHT_W) ? NW : WEIGHT_W;
    localparam int BCW = $clog2(DATA_BITS + 2);

    localparam logic [2:0] PH_IDLE = 3'd0;
    localparam logic [2:0] PH_LEAD = 3'd1;
    localparam logic [2:0] PH_WAIT = 3'd2;
    localparam logic [2:0] PH_HIGH = 3'd3;
    localparam logic [2:0] PH_LOW  = 3'd4;

    logic [HALF_W-1:0]    half_reg;
    logic [GAP_W-1:0]     gap_reg;

    logic [2:0]           phase_reg,  phase_next;
    logic [HALF_W-1:0]    tick_reg,   tick_next;
    logic [BCW-1:0]       bit_reg,    bit_next;
    logic [DATA_BITS-1:0] shift_reg,  shift_next;
    logic                 sck_reg,    sck_next;
    logic                 tare_reg,   tare_next;
    logic [DATA_BITS-1:0] last_raw_reg;
    logic [DATA_BITS-1:0] tare_val_reg;
    logic [WEIGHT_W-1:0]  net_weight_reg;

    logic                 m_valid_reg;
    lcadc_out_t           m_data_reg;

    logic                 accept;
    logic                 finish;
    logic [BCW-1:0]       bit_inc;
    logic [HALF_W-1:0]    tick_inc;
    logic [DATA_BITS-1:0] raw_fin;
    logic                 above_tare;
    logic                 upd;
    logic                 div_start;
    logic [NW-1:0]        div_num;
    logic [NW-1:0]        div_quo;
    logic [QW-1:0]        quo_ext;
    logic [WEIGHT_W-1:0]  quo_sat;
    logic [WEIGHT_W-1:0]  weight_out;
    logic [DATA_BITS-1:0] raw_out;
    lcadc_div_stat_t      div_stat;

    // One beat in flight: the divider and a full output register both hold off the input.
    assign s_ready = !div_stat.busy && !div_stat.done && (!m_valid_reg || m_ready);
    assign accept  = s_valid && s_ready;

    always_comb begin
        phase_next = phase_reg;
        tick_next  = tick_reg;
        bit_next   = bit_reg;
        shift_next = shift_reg;
        sck_next   = sck_reg;
        tare_next  = tare_reg;
        finish     = 1'b0;
        bit_inc    = bit_reg + 1'b1;
        tick_inc   = (tick_reg != '1) ? (tick_reg + 1'b1) : tick_reg;
        unique case (phase_reg)
            PH_IDLE: begin
                if (s_data.mode == MODE_WEIGH || s_data.mode == MODE_TARE) begin
                    tare_next  = (s_data.mode == MODE_TARE);
                    sck_next   = 1'b1;
                    tick_next  = HALF_W'(1);
                    bit_next   = '0;
                    shift_next = '0;
                    phase_next = PH_LEAD;
                end
            end
            PH_LEAD: begin
                if (tick_reg >= half_reg) begin
                    sck_next   = 1'b0;
                    tick_next  = '0;
                    phase_next = PH_WAIT;
                end else begin
                    tick_next = tick_reg + 1'b1;
                end
            end
            PH_WAIT: begin
                if (!s_data.dout_pin) begin
                    sck_next   = 1'b1;
                    tick_next  = HALF_W'(1);
                    bit_next   = '0;
                    phase_next = PH_HIGH;
                end
            end
            PH_HIGH: begin
                if (tick_reg >= half_reg) begin
                    sck_next  = 1'b0;
                    tick_next = '0;
                    // The pulse after the last data bit selects gain 128 and ends the read.
                    if (bit_inc > BCW'(DATA_BITS)) begin
                        phase_next = PH_IDLE;
                        finish     = 1'b1;
                        bit_next   = '0;
                    end else begin
                        phase_next = PH_LOW;
                        bit_next   = bit_inc;
                    end
                end else begin
                    tick_next = tick_reg + 1'b1;
                end
            end
            PH_LOW: begin
                tick_next = tick_inc;
                if (tick_inc == HALF_W'(1)) begin
                    shift_next = {shift_reg[DATA_BITS-2:0], s_data.dout_pin};
                end
                if (tick_inc >= half_reg) begin
                    sck_next   = 1'b1;
                    tick_next  = HALF_W'(1);
                    phase_next = PH_HIGH;
                end
            end
            default: begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    always_comb begin
        raw_fin    = {~shift_reg[DATA_BITS-1], shift_reg[DATA_BITS-2:0]};
        above_tare = (raw_fin > tare_val_reg);
        upd        = finish && !tare_reg && above_tare;
        div_start  = accept && upd && (gap_reg != '0);
        div_num    = NW'(raw_fin - tare_val_reg) << (FRAC_BITS + 1);
        weight_out = (upd && gap_reg == '0) ? WEIGHT_MAX : net_weight_reg;
        raw_out    = finish ? raw_fin : last_raw_reg;
        quo_ext    = QW'(div_quo);
        quo_sat    = (quo_ext > QW'(WEIGHT_MAX)) ? WEIGHT_MAX : WEIGHT_W'(quo_ext);
    end

    lcadc_div #(
        .NW (NW),
        .DW (GAP_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_num),
        .divisor  (gap_reg),
        .quotient (div_quo),
        .stat     (div_stat)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            half_reg       <= HALF_RST;
            gap_reg        <= GAP_RST;
            phase_reg      <= PH_IDLE;
            tick_reg       <= '0;
            bit_reg        <= '0;
            shift_reg      <= '0;
            sck_reg        <= 1'b1;
            tare_reg       <= 1'b0;
            last_raw_reg   <= '0;
            tare_val_reg   <= '0;
            net_weight_reg <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    REG_HALF: half_reg <= cfg_wr_data[HALF_W-1:0];
                    REG_GAP:  gap_reg  <= cfg_wr_data;
                    default:  ;
                endcase
            end
            if (accept) begin
                phase_reg <= phase_next;
                tick_reg  <= tick_next;
                bit_reg   <= bit_next;
                shift_reg <= shift_next;
                sck_reg   <= sck_next;
                tare_reg  <= tare_next;
                if (finish) begin
                    last_raw_reg <= raw_fin;
                    if (tare_reg) begin
                        tare_val_reg <= raw_fin;
                    end
                end
                if (upd && gap_reg == '0) begin
                    net_weight_reg <= WEIGHT_MAX;
                end
            end
            if (div_stat.done) begin
                net_weight_reg <= quo_sat;
            end
            if ((accept && !div_start) || div_stat.done) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // The result beat is staged here; a beat waiting on the divider stays hidden until
    // the quotient lands in its weight field.
    always_ff @(posedge aclk) begin
        if (accept) begin
            m_data_reg.sck_pin        <= sck_next;
            m_data_reg.busy_res       <= (phase_next != PH_IDLE);
            m_data_reg.done_res       <= finish;
            m_data_reg.raw_value      <= RAW_W'(raw_out);
            m_data_reg.weight         <= weight_out;
            m_data_reg.weight_updated <= upd;
        end else if (div_stat.done) begin
            m_data_reg.weight <= quo_sat;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
`default_nettype wire

/* rtl/lcadc_checker.sv */
`default_nettype none
`include "load_cell_adc_reader_with_tare_top_assert.svh"
module lcadc_checker
    import lcadc_pkg::*;
(
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       s_valid,
    input wire logic       s_ready,
    input wire logic       m_valid,
    input wire logic       m_ready,
    input wire lcadc_out_t m_data
);

    // A stalled result beat must be held unchanged.
    `LCADC_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_data))

    // A waiting result beat leaves no room for another input beat.
    `LCADC_ASSERT_SAME(a_no_accept_full, aclk, aresetn, m_valid && !m_ready, !s_ready)

    // A completed read leaves the block idle with the clock low.
    `LCADC_ASSERT_SAME(a_done_idle, aclk, aresetn, m_valid && m_data.done_res,
                       !m_data.busy_res && !m_data.sck_pin)

    // A weight update only happens on the beat that completes a read.
    `LCADC_ASSERT_SAME(a_upd_done, aclk, aresetn, m_valid && m_data.weight_updated,
                       m_data.done_res)

    // The input is blocked while a result beat is in preparation or waiting.
    `LCADC_ASSERT_NEXT(a_one_in_flight, aclk, aresetn, s_valid && s_ready, !s_ready || m_valid)

endmodule

bind load_cell_adc_reader_with_tare_top lcadc_checker u_lcadc_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
`default_nettype wire
